FILE: hw/rtl/mmrab_pkg.sv
// Shared types, constants and the sequencer program for the region-to-block core.
// No dependencies.
package mmrab_pkg;

  localparam int unsigned CW      = 33;
  localparam int unsigned ORDER_W = 5;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned STEP_W  = 3;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_RESERVE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLE_START   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLE_RESUME  = 2'd2;

  localparam logic [24:0] RST_LOW_RESERVE = 25'h0080000;
  localparam logic [23:0] RST_HOLE_START  = 24'h100000;
  localparam logic [31:0] RST_HOLE_RESUME = 32'h00400000;

  localparam logic [31:0] KIND_AVAILABLE = 32'd1;

  typedef struct packed {
    logic [31:0] region_base;
    logic [31:0] region_length;
    logic [31:0] region_kind;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        block_base;
    logic [ORDER_W-1:0] block_order;
    logic [SUM_W-1:0]   usable_total;
    logic               last_block;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLIP,
    OP_SPLIT,
    OP_PIECE,
    OP_EMIT,
    OP_NEXT
  } op_e;

  typedef enum logic [2:0] {
    C_FALL,
    C_ALWAYS,
    C_NO_INPUT,
    C_REJECT,
    C_EMPTY,
    C_EMIT_STAY,
    C_NO_SECOND
  } cond_e;

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic reject;
    logic empty;
    logic emit_stay;
    logic no_second;
  } cond_flags_t;

  localparam logic [STEP_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [STEP_W-1:0] ST_CHECK = 3'd1;
  localparam logic [STEP_W-1:0] ST_CLIP  = 3'd2;
  localparam logic [STEP_W-1:0] ST_SPLIT = 3'd3;
  localparam logic [STEP_W-1:0] ST_PIECE = 3'd4;
  localparam logic [STEP_W-1:0] ST_EMIT  = 3'd5;
  localparam logic [STEP_W-1:0] ST_NEXT  = 3'd6;
  localparam logic [STEP_W-1:0] ST_LOOP  = 3'd7;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    unique case (step)
      ST_IDLE:  w = '{op: OP_LOAD,  cond: C_NO_INPUT,  target: ST_IDLE};
      ST_CHECK: w = '{op: OP_NONE,  cond: C_REJECT,    target: ST_IDLE};
      ST_CLIP:  w = '{op: OP_CLIP,  cond: C_FALL,      target: ST_IDLE};
      ST_SPLIT: w = '{op: OP_SPLIT, cond: C_FALL,      target: ST_IDLE};
      ST_PIECE: w = '{op: OP_PIECE, cond: C_EMPTY,     target: ST_NEXT};
      ST_EMIT:  w = '{op: OP_EMIT,  cond: C_EMIT_STAY, target: ST_EMIT};
      ST_NEXT:  w = '{op: OP_NEXT,  cond: C_NO_SECOND, target: ST_IDLE};
      ST_LOOP:  w = '{op: OP_NONE,  cond: C_ALWAYS,    target: ST_PIECE};
      default:  w = '{op: OP_NONE,  cond: C_ALWAYS,    target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/memory_map_region_to_aligned_blocks_core.sv
// Blocks of an entry come out one per cycle while the output is not stalled; the step
// sequencer sets the rate and takes a new entry only once it is back at its idle step,
// so all blocks of an entry are issued before the next entry is accepted.
// Reset clears the step counter, the output valid and the byte total, and loads the
// configuration registers with their defaults. Depends on mmrab_pkg and mmrab_seq.
module memory_map_region_to_aligned_blocks_core import mmrab_pkg::*; #(
  parameter int unsigned PAGE_SHIFT = 12,
  parameter int unsigned ADDR_BITS  = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned PGW = ADDR_BITS - PAGE_SHIFT + 1;
  localparam logic [CW-1:0] LIMIT = CW'(1) << ADDR_BITS;
  localparam logic [CW-1:0] PG_MASK = (CW'(1) << PAGE_SHIFT) - CW'(1);

  logic [24:0] res_q;
  logic [23:0] hole_q;
  logic [31:0] resume_q;

  logic [CW-1:0]      base_q, end_q, cur_start_q, cur_end_q, p2_start_q;
  logic               kind_ok_q, has2_q, p2pg_q;
  logic [PGW-1:0]     first_q, stop_q;
  logic [SUM_W-1:0]   sum_q;
  logic               out_valid_q;
  out_item_t          out_q;

  ucode_t       word;
  cond_flags_t  flags;

  logic [CW-1:0]      res_w, hole_w, resume_w, end_full, end_clamp, p2s, ceil2;
  logic               split, can_load, emit_go, piece_ne;
  logic [PGW-1:0]     span, nxt, low_mask;
  logic [ORDER_W-1:0] order;
  logic [SUM_W:0]     sum_ext;

  assign res_w    = CW'(res_q);
  assign hole_w   = CW'(hole_q);
  assign resume_w = CW'(resume_q);

  assign end_full  = CW'(in_data_i.region_base) + CW'(in_data_i.region_length);
  assign end_clamp = (end_full > LIMIT) ? LIMIT : end_full;

  assign split = (base_q <= hole_w) && (hole_w < end_q);
  assign p2s   = (res_w > resume_w) ? res_w : resume_w;
  assign ceil2 = (p2s + PG_MASK) >> PAGE_SHIFT;

  assign piece_ne = cur_start_q < cur_end_q;
  assign sum_ext  = {1'b0, sum_q} + (SUM_W + 1)'(cur_end_q - cur_start_q);

  assign span = stop_q - first_q;
  always_comb begin
    order = '0;
    for (int o = 1; o < PGW; o++) begin
      low_mask = (PGW'(1) << o) - PGW'(1);
      if (((first_q & low_mask) == '0) && ((span >> o) != '0)) begin
        order = ORDER_W'(o);
      end
    end
    if (PGW == 1) begin
      low_mask = '0;
    end
  end
  assign nxt = first_q + (PGW'(1) << order);

  assign can_load = !out_valid_q || !out_stall_i;
  assign emit_go  = (word.op == OP_EMIT) && (first_q < stop_q) && can_load;

  assign flags.in_valid  = in_valid_i;
  assign flags.reject    = !kind_ok_q || (base_q >= end_q) ||
                           ((base_q < res_w) && (end_q <= res_w));
  assign flags.empty     = !piece_ne;
  assign flags.emit_stay = (first_q < stop_q) && !(can_load && (nxt >= stop_q));
  assign flags.no_second = !has2_q;

  mmrab_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .word_o  (word)
  );

  assign in_stall_o  = word.op != OP_LOAD;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q    <= RST_LOW_RESERVE;
      hole_q   <= RST_HOLE_START;
      resume_q <= RST_HOLE_RESUME;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOW_RESERVE: res_q    <= cfg_data_i[24:0];
        CFG_HOLE_START:  hole_q   <= cfg_data_i[23:0];
        CFG_HOLE_RESUME: resume_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      has2_q      <= 1'b0;
      p2pg_q      <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (word.op == OP_SPLIT) begin
        has2_q <= split;
        p2pg_q <= split && (p2s < end_q) && (ceil2 < (end_q >> PAGE_SHIFT));
      end
      if ((word.op == OP_NEXT) && has2_q) begin
        has2_q <= 1'b0;
        p2pg_q <= 1'b0;
      end
      if ((word.op == OP_PIECE) && piece_ne) begin
        sum_q <= (sum_ext > {1'b0, SUM_MAX}) ? SUM_MAX : sum_ext[SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (word.op)
      OP_LOAD: begin
        if (in_valid_i) begin
          base_q    <= CW'(in_data_i.region_base);
          end_q     <= end_clamp;
          kind_ok_q <= in_data_i.region_kind == KIND_AVAILABLE;
        end
      end
      OP_CLIP: begin
        if (base_q < res_w) begin
          base_q <= res_w;
        end
      end
      OP_SPLIT: begin
        cur_start_q <= base_q;
        cur_end_q   <= split ? hole_w : end_q;
        p2_start_q  <= p2s;
      end
      OP_PIECE: begin
        first_q <= PGW'((cur_start_q + PG_MASK) >> PAGE_SHIFT);
        stop_q  <= PGW'(cur_end_q >> PAGE_SHIFT);
      end
      OP_EMIT: begin
        if (emit_go) begin
          first_q                <= nxt;
          out_q.block_base       <= 32'(CW'(first_q) << PAGE_SHIFT);
          out_q.block_order      <= order;
          out_q.usable_total     <= sum_q;
          out_q.last_block       <= (nxt >= stop_q) && !p2pg_q;
        end
      end
      OP_NEXT: begin
        if (has2_q) begin
          cur_start_q <= p2_start_q;
          cur_end_q   <= end_q;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/mmrab_seq.sv
// Step counter and control store of the region-to-block core.
// Depends on mmrab_pkg.
module mmrab_seq import mmrab_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cond_flags_t flags_i,
  output ucode_t      word_o
);

  logic [STEP_W-1:0] pc_q, pc_d;
  ucode_t            word;
  logic              take;

  assign word   = ucode_rom(pc_q);
  assign word_o = word;

  always_comb begin
    unique case (word.cond)
      C_FALL:      take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_INPUT:  take = !flags_i.in_valid;
      C_REJECT:    take = flags_i.reject;
      C_EMPTY:     take = flags_i.empty;
      C_EMIT_STAY: take = flags_i.emit_stay;
      C_NO_SECOND: take = flags_i.no_second;
      default:     take = 1'b1;
    endcase
    pc_d = take ? word.target : pc_q + STEP_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

FILE: hw/rtl/mmrab_chk.sv
// Port-level checks for the region-to-block core, attached by bind.
// Depends on mmrab_pkg.
module mmrab_chk import mmrab_pkg::*; #(
  parameter int unsigned PAGE_SHIFT = 12,
  parameter int unsigned ADDR_BITS  = 32
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input out_item_t            out_data_o
);

  logic out_xfer;
  logic [31:0] blk_pages, blk_mask;

  assign out_xfer  = out_valid_o && !out_stall_i;
  assign blk_pages = out_data_o.block_base >> PAGE_SHIFT;
  assign blk_mask  = (32'd1 << out_data_o.block_order) - 32'd1;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled transfer changed");

  a_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((blk_pages & blk_mask) == 32'd0) &&
                    (out_data_o.block_base[PAGE_SHIFT-1:0] == '0))
    else $error("block not aligned to its size");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.block_order <= ORDER_W'(ADDR_BITS - PAGE_SHIFT))
    else $error("block order beyond address range");

  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && !out_data_o.last_block ##1 out_xfer |->
      out_data_o.usable_total >= $past(out_data_o.usable_total))
    else $error("running total went down within an entry");

endmodule

bind memory_map_region_to_aligned_blocks_core mmrab_chk #(
  .PAGE_SHIFT (PAGE_SHIFT),
  .ADDR_BITS  (ADDR_BITS)
) u_mmrab_chk (.*);
